[sv/assert_macros.svh]
// Assertion helpers, clocked on the rising edge, disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check with a message.
`define ASSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent implication checked every cycle: cond implies expr.
`define ASSD_ASSERT_IMPL(lbl, clk, rst_n, cond, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

`endif

[sv/assd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package assd_pkg;

    localparam int WINDOW_DEF  = 100;
    localparam int SAMPLE_W    = 10;
    localparam int SUM_W       = 17;
    localparam int AVG_W       = 10;
    localparam int DIGIT_W     = 4;
    localparam int POS_W       = 2;
    localparam int SEG_W       = 8;

    localparam logic [POS_W-1:0] POS_ONES      = 2'd0;
    localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd3;

    // x / 10 == (x * 205) >> 11 for every 10-bit x
    localparam int DIV10_MUL   = 205;
    localparam int DIV10_SHIFT = 11;
    localparam int DEC_BASE    = 10;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'd0:    p = 8'hC0;
            4'd1:    p = 8'hF9;
            4'd2:    p = 8'hA4;
            4'd3:    p = 8'hB0;
            4'd4:    p = 8'h99;
            4'd5:    p = 8'h92;
            4'd6:    p = 8'h82;
            4'd7:    p = 8'hF8;
            4'd8:    p = 8'h80;
            4'd9:    p = 8'h90;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[sv/assd_digit_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module assd_digit_out (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         load_valid,
    input  wire logic [assd_pkg::AVG_W-1:0]   avg,
    output logic                              load_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [assd_pkg::POS_W-1:0]        digit_position,
    output logic [assd_pkg::SEG_W-1:0]        segment_pattern,
    output logic                              last_digit
);

    localparam int MUL_W = assd_pkg::AVG_W + 8;

    logic                            valid_reg;
    logic                            valid_next;
    logic [assd_pkg::POS_W-1:0]      pos_reg;
    logic [assd_pkg::POS_W-1:0]      pos_next;
    logic [assd_pkg::AVG_W-1:0]      q_reg;

    logic [MUL_W-1:0]                q_mul;
    logic [assd_pkg::AVG_W-1:0]      quot;
    logic [assd_pkg::AVG_W-1:0]      rem;
    logic                            is_last;
    logic                            load;
    logic                            advance;

    assign q_mul   = MUL_W'(q_reg) * MUL_W'(assd_pkg::DIV10_MUL);
    assign quot    = assd_pkg::AVG_W'(q_mul >> assd_pkg::DIV10_SHIFT);
    assign rem     = q_reg - assd_pkg::AVG_W'(quot * assd_pkg::AVG_W'(assd_pkg::DEC_BASE));
    assign is_last = (pos_reg == assd_pkg::POS_THOUSANDS);

    assign load_ready = !valid_reg || (out_ready && is_last);
    assign load       = load_valid && load_ready;
    assign advance    = valid_reg && out_ready && !is_last;

    always_comb
    begin
        valid_next = valid_reg;
        pos_next   = pos_reg;
        priority if (load)
        begin
            valid_next = 1'b1;
            pos_next   = assd_pkg::POS_ONES;
        end
        else if (valid_reg && out_ready)
        begin
            valid_next = !is_last;
            pos_next   = pos_reg + assd_pkg::POS_W'(1);
        end
        else
        begin
            valid_next = valid_reg;
            pos_next   = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pos_reg   <= assd_pkg::POS_ONES;
        end
        else
        begin
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= avg;
        end
        else if (advance)
        begin
            q_reg <= quot;
        end
    end

    assign out_valid       = valid_reg;
    assign digit_position  = pos_reg;
    assign segment_pattern = assd_pkg::seg_pattern(rem[assd_pkg::DIGIT_W-1:0]);
    assign last_digit      = is_last;

endmodule

`default_nettype wire

[sv/averaged_sample_seven_segment_display.sv]
// Moving average of converter samples, shown as four seven-segment digits.
// Input channel: in_valid/in_ready carry one 10-bit sample per transaction.
// Output channel: out_valid/out_ready carry four transactions per sample, in the
// order ones, tens, hundreds, thousands; last_digit marks the thousands digit.
// segment_pattern is active low, bit 7 is the decimal point and stays off.
// The sample ring lives in a WINDOW-deep synchronous RAM; the old entry is read
// and the new sample written in the cycle the sample is taken.
// The sample is registered on entry, then the running sum, the reciprocal product
// and the digit register are updated in turn; the average waits in the product
// register while the previous digits are still going out. The sample rate is set
// by the single digit output port, which carries four digits per sample. The next
// sample enters while the current digits are still being shown.
// Reset clears the running sum, the write pointer and a wrap flag; ring slots
// not yet written read as zero, so early averages count them as zeros. No
// clearing pass is needed.
// When the receiver stalls, the digit on the output holds, one further sample
// is taken and waits in the pipeline, then in_ready drops.
`timescale 1ns / 1ps
`default_nettype none

module averaged_sample_seven_segment_display #(
    parameter int WINDOW = assd_pkg::WINDOW_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [assd_pkg::SAMPLE_W-1:0]   sample,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic [assd_pkg::POS_W-1:0]           digit_position,
    output logic [assd_pkg::SEG_W-1:0]           segment_pattern,
    output logic                                 last_digit
);

    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SHIFT  = assd_pkg::SUM_W + $clog2(WINDOW);
    localparam int REC_W  = assd_pkg::SUM_W + 1;
    localparam int PROD_W = assd_pkg::SUM_W + REC_W;
    localparam logic [REC_W-1:0] RECIP =
        REC_W'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);

    logic [assd_pkg::SAMPLE_W-1:0] mem [WINDOW];
    logic [assd_pkg::SAMPLE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0]              wr_idx_reg;
    logic [IDX_W-1:0]              wr_idx_next;
    logic                          wrapped_reg;
    logic                          v1_reg;
    logic                          v2_reg;
    logic                          v3_reg;
    logic                          old_ok_reg;
    logic [assd_pkg::SAMPLE_W-1:0] s1_reg;
    logic [assd_pkg::SUM_W-1:0]    sum_reg;
    logic [assd_pkg::SUM_W-1:0]    sum_next;
    logic [PROD_W-1:0]             prod_reg;

    logic                          accept;
    logic                          load_ready;
    logic                          out_load;
    logic [assd_pkg::SAMPLE_W-1:0] old_sample;
    logic [PROD_W-1:0]             prod_sh;
    logic [assd_pkg::AVG_W-1:0]    avg;

    assign accept   = in_valid && in_ready;
    assign out_load = v3_reg && load_ready;
    assign in_ready = !v1_reg && !v2_reg && (!v3_reg || load_ready);

    assign wr_idx_next = (wr_idx_reg == IDX_LAST) ? '0 : wr_idx_reg + IDX_W'(1);

    assign old_sample = old_ok_reg ? rd_data_reg : '0;
    assign sum_next   = sum_reg - assd_pkg::SUM_W'(old_sample)
                        + assd_pkg::SUM_W'(s1_reg);

    assign prod_sh = prod_reg >> SHIFT;
    assign avg     = prod_sh[assd_pkg::AVG_W-1:0];

    // read-old, write-new on the same slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg     <= mem[wr_idx_reg];
            mem[wr_idx_reg] <= sample;
            s1_reg          <= sample;
        end
        if (v2_reg)
        begin
            prod_reg <= PROD_W'(sum_reg) * PROD_W'(RECIP);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            wrapped_reg <= 1'b0;
            old_ok_reg  <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            if (accept)
            begin
                wr_idx_reg <= wr_idx_next;
                old_ok_reg <= wrapped_reg;
                if (wr_idx_reg == IDX_LAST)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            if (v1_reg)
            begin
                sum_reg <= sum_next;
            end
            priority if (v2_reg)
            begin
                v3_reg <= 1'b1;
            end
            else if (out_load)
            begin
                v3_reg <= 1'b0;
            end
            else
            begin
                v3_reg <= v3_reg;
            end
        end
    end

    assd_digit_out u_digit_out (
        .clk             (clk),
        .rst_n           (rst_n),
        .load_valid      (v3_reg),
        .avg             (avg),
        .load_ready      (load_ready),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .digit_position  (digit_position),
        .segment_pattern (segment_pattern),
        .last_digit      (last_digit)
    );

endmodule

`default_nettype wire

[sv/assd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module assd_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            in_valid,
    input wire logic                            in_ready,
    input wire logic [assd_pkg::SAMPLE_W-1:0]   sample,
    input wire logic                            out_valid,
    input wire logic                            out_ready,
    input wire logic [assd_pkg::POS_W-1:0]      digit_position,
    input wire logic [assd_pkg::SEG_W-1:0]      segment_pattern,
    input wire logic                            last_digit
);

    logic in_txn;
    logic out_txn;

    assign in_txn  = in_valid && in_ready && (sample == sample);
    assign out_txn = out_valid && out_ready;

    `ASSD_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(digit_position) && $stable(segment_pattern), "output changed while stalled")
    `ASSD_ASSERT_IMPL(a_last_pos, clk, rst_n, out_valid, last_digit == (digit_position == assd_pkg::POS_THOUSANDS), "last flag off the thousands digit")
    `ASSD_ASSERT(a_digit_seq, clk, rst_n, out_txn && !last_digit |=> out_valid && (digit_position == $past(digit_position) + 2'd1), "digit run broken")
    `ASSD_ASSERT_IMPL(a_dp_off, clk, rst_n, out_valid, segment_pattern[7] == 1'b1, "decimal point lit")
    `ASSD_ASSERT(a_one_entry, clk, rst_n, in_txn |=> !in_ready, "second sample taken while first enters")

endmodule

bind averaged_sample_seven_segment_display assd_checker u_assd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample          (sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .digit_position  (digit_position),
    .segment_pattern (segment_pattern),
    .last_digit      (last_digit)
);

`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    localparam int SAMPLE_W    = assd_pkg::SAMPLE_W;
    localparam int SUM_W       = assd_pkg::SUM_W;
    localparam int POS_W       = assd_pkg::POS_W;
    localparam int SEG_W       = assd_pkg::SEG_W;
    localparam int AVG_WINDOW  = assd_pkg::WINDOW_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;

    typedef enum logic [POS_W-1:0] {
        DIG_ONES      = assd_pkg::POS_ONES,
        DIG_TENS      = 2'd1,
        DIG_HUNDREDS  = 2'd2,
        DIG_THOUSANDS = assd_pkg::POS_THOUSANDS
    } digit_pos_e;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [SEG_W-1:0] seg;
        logic             last;
    } digit_xact_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        bit                  typed;
        logic [31:0]         segs;   // {thousands, hundreds, tens, ones}
    } stim_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [SAMPLE_W-1:0] sample;
    logic                out_valid;
    logic                out_ready;
    logic [POS_W-1:0]    digit_position;
    logic [SEG_W-1:0]    segment_pattern;
    logic                last_digit;

    logic [SAMPLE_W-1:0] window_ring [AVG_WINDOW];
    int unsigned         window_wr_idx;
    logic [SUM_W-1:0]    window_sum;
    digit_xact_t         pending_digits [$];

    int unsigned errors;
    int unsigned cycles;
    int unsigned samples_sent;
    int unsigned digits_checked;
    int unsigned peak_average;
    int unsigned burst_left;

    stim_row_t directed_rows [20];

    averaged_sample_seven_segment_display dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .digit_position  (digit_position),
        .segment_pattern (segment_pattern),
        .last_digit      (last_digit)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t timeout with %0d digits outstanding", $time, pending_digits.size());
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [SEG_W-1:0] led_code(input int unsigned d);
        logic [SEG_W-1:0] p;
        case (d)
            0:       p = 8'b11000000;
            1:       p = 8'b11111001;
            2:       p = 8'b10100100;
            3:       p = 8'b10110000;
            4:       p = 8'b10011001;
            5:       p = 8'b10010010;
            6:       p = 8'b10000010;
            7:       p = 8'b11111000;
            8:       p = 8'b10000000;
            9:       p = 8'b10010000;
            default: p = 8'b11111111;
        endcase
        return p;
    endfunction

    // Update the window, then queue the four digits of the new average.
    task automatic record_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                                 input logic [31:0] segs);
        int unsigned avg;
        int unsigned k;
        digit_xact_t d;
        begin
            window_sum = window_sum - window_ring[window_wr_idx] + s;
            window_ring[window_wr_idx] = s;
            window_wr_idx = (window_wr_idx == AVG_WINDOW - 1) ? 0 : window_wr_idx + 1;
            avg = window_sum / AVG_WINDOW;
            if (avg > peak_average)
                peak_average = avg;
            for (k = 0; k < 4; k++)
            begin
                d.pos  = k[POS_W-1:0];
                d.seg  = typed ? segs[8*k +: 8] : led_code(avg % 10);
                d.last = (d.pos == DIG_THOUSANDS);
                pending_digits.push_back(d);
                avg = avg / 10;
            end
            samples_sent++;
        end
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                               input logic [31:0] segs);
        int unsigned gap;
        begin
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                burst_left = $urandom_range(1, 12);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
            in_valid <= 1'b1;
            sample   <= s;
            @(posedge clk);
            while (!in_ready) @(posedge clk);
            record_sample(s, typed, segs);
        end
    endtask

    initial
    begin
        directed_rows[0]  = '{10'd1023, 1'b1, 32'hC0C0F9C0};  // avg 10
        directed_rows[1]  = '{10'd1023, 1'b1, 32'hC0C0A4C0};  // avg 20
        directed_rows[2]  = '{10'd0,    1'b1, 32'hC0C0A4C0};
        directed_rows[3]  = '{10'd1,    1'b1, 32'hC0C0A4C0};
        directed_rows[4]  = '{10'd512,  1'b0, 32'h0};
        directed_rows[5]  = '{10'd341,  1'b0, 32'h0};
        directed_rows[6]  = '{10'd682,  1'b0, 32'h0};
        directed_rows[7]  = '{10'd256,  1'b0, 32'h0};
        directed_rows[8]  = '{10'd128,  1'b0, 32'h0};
        directed_rows[9]  = '{10'd64,   1'b0, 32'h0};
        directed_rows[10] = '{10'd32,   1'b0, 32'h0};
        directed_rows[11] = '{10'd16,   1'b0, 32'h0};
        directed_rows[12] = '{10'd8,    1'b0, 32'h0};
        directed_rows[13] = '{10'd4,    1'b0, 32'h0};
        directed_rows[14] = '{10'd2,    1'b0, 32'h0};
        directed_rows[15] = '{10'd1023, 1'b0, 32'h0};
        directed_rows[16] = '{10'd1023, 1'b0, 32'h0};
        directed_rows[17] = '{10'd999,  1'b0, 32'h0};
        directed_rows[18] = '{10'd0,    1'b0, 32'h0};
        directed_rows[19] = '{10'd1000, 1'b0, 32'h0};
    end

    initial
    begin
        int unsigned i;
        int unsigned mode;
        int unsigned run_len;
        logic [SAMPLE_W-1:0] s;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        sample         = '0;
        samples_sent   = 0;
        peak_average   = 0;
        burst_left     = 0;
        window_wr_idx  = 0;
        window_sum     = '0;
        for (i = 0; i < AVG_WINDOW; i++)
            window_ring[i] = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < $size(directed_rows); i++)
            send_sample(directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].segs);

        // a full window at full scale drives the average to its ceiling
        for (i = 0; i < AVG_WINDOW; i++)
            send_sample(10'd1023, 1'b0, 32'h0);

        i = 0;
        while (i < 40)
        begin
            mode    = $urandom_range(0, 3);
            run_len = $urandom_range(1, 15);
            repeat (run_len)
            begin
                case (mode)
                    0:       s = SAMPLE_W'($urandom_range(0, 1023));
                    1:       s = 10'd1023;
                    2:       s = 10'd0;
                    default: s = SAMPLE_W'($urandom_range(900, 1023));
                endcase
                send_sample(s, 1'b0, 32'h0);
                i++;
            end
        end
        in_valid <= 1'b0;

        while (pending_digits.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("tb: %0d samples through a %0d-deep window, %0d digits checked",
                 samples_sent, AVG_WINDOW, digits_checked);
        $display("tb: highest average shown %0d, %0d mismatches", peak_average, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [15:0] stall_mask;
        int unsigned k;

        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall_mask = 16'($urandom);
            stall_mask[0] = 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_mask = '1;
            for (k = 0; k < 64; k++)
            begin
                @(posedge clk);
                out_ready <= stall_mask[k % 16];
            end
        end
    end

    always @(posedge clk)
    begin
        digit_xact_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_digits.size() == 0)
            begin
                $display("%0t unexpected transaction: pos %0d seg %h last %b",
                         $time, digit_position, segment_pattern, last_digit);
                errors++;
            end
            else
            begin
                want = pending_digits.pop_front();
                digits_checked++;
                if (digit_position !== want.pos)
                begin
                    $display("%0t digit_position: expected %0d, actual %0d",
                             $time, want.pos, digit_position);
                    errors++;
                end
                if (segment_pattern !== want.seg)
                begin
                    $display("%0t segment_pattern (pos %0d): expected %h, actual %h",
                             $time, want.pos, want.seg, segment_pattern);
                    errors++;
                end
                if (last_digit !== want.last)
                begin
                    $display("%0t last_digit (pos %0d): expected %b, actual %b",
                             $time, want.pos, want.last, last_digit);
                    errors++;
                end
            end
        end
    end

endmodule
